// File: src/tsq_pkg.sv
// tsq_pkg: shared types and constants of the thermocouple sample qualifier
`default_nettype none

package tsq_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_PROBE_ENABLE    = 3'd0;
   localparam logic [2:0] REG_MAX_TEMP        = 3'd1;
   localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd2;
   localparam logic [2:0] REG_JUMP_LIMIT      = 3'd3;
   localparam logic [2:0] REG_ERROR_LIMIT     = 3'd4;

   // register reset values
   localparam logic [9:0]  MAX_TEMP_RESET        = 10'd1023;
   localparam logic [15:0] SAMPLE_INTERVAL_RESET = 16'd100;
   localparam logic [9:0]  JUMP_LIMIT_RESET      = 10'd50;
   localparam logic [2:0]  ERROR_LIMIT_RESET     = 3'd4;

   // range margin above max_temp and saturation points
   localparam logic [10:0] RANGE_MARGIN = 11'd5;
   localparam logic [15:0] TICK_MAX     = 16'hFFFF;
   localparam logic [2:0]  ERRORS_MAX   = 3'd7;

   // result status codes
   typedef enum logic [2:0] {
      ST_WAIT   = 3'd0,
      ST_OK     = 3'd1,
      ST_OPEN   = 3'd2,
      ST_RANGE  = 3'd3,
      ST_JUMP   = 3'd4,
      ST_OFF    = 3'd5,
      ST_FAILED = 3'd6
   } status_type;

   typedef struct packed {
      logic        probe_enable;
      logic [9:0]  max_temp;
      logic [15:0] sample_interval;
      logic [9:0]  jump_limit;
      logic [2:0]  error_limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0] tick_count;
      logic [9:0]  held_temp;
      logic [2:0]  error_count;
      logic        probe_failed;
   } state_type;

   typedef struct packed {
      logic [2:0]  errors_now;
      status_type  status;
      logic [9:0]  temperature;
   } result_type;

endpackage

`default_nettype wire

// File: src/tsq_step.sv
// tsq_step: next-state and result logic for one tick transaction
`default_nettype none

module tsq_step
   import tsq_pkg::*;
(
   input  wire cfg_type    cfg,
   input  wire state_type  state_now,
   input  wire [15:0]      converter_word,
   output state_type       state_next,
   output result_type      result
);

   logic [15:0] tick_inc;
   logic [9:0]  value;
   logic [9:0]  diff;
   logic [10:0] range_top;
   logic [2:0]  errors_bumped;

   // saturating tick count, scaled value and its distance from the held value
   always_comb begin
      tick_inc      = (state_now.tick_count == TICK_MAX) ? state_now.tick_count
                                                         : state_now.tick_count + 16'd1;
      value         = converter_word[14:5];
      diff          = (value > state_now.held_temp) ? value - state_now.held_temp
                                                    : state_now.held_temp - value;
      range_top     = {1'b0, cfg.max_temp} + RANGE_MARGIN;
      errors_bumped = (state_now.error_count == ERRORS_MAX) ? state_now.error_count
                                                            : state_now.error_count + 3'd1;
   end

   // qualification decision
   always_comb begin
      state_next            = state_now;
      state_next.tick_count = tick_inc;
      result.temperature    = state_now.held_temp;
      result.status         = ST_WAIT;
      if (!cfg.probe_enable || state_now.probe_failed) begin
         state_next.held_temp = '0;
         result.temperature   = '0;
         result.status        = ST_OFF;
      end else if (tick_inc > cfg.sample_interval) begin
         state_next.tick_count = '0;
         if (state_now.error_count > cfg.error_limit) begin
            state_next.probe_failed = 1'b1;
            state_next.error_count  = '0;
            state_next.held_temp    = '0;
            result.temperature      = '0;
            result.status           = ST_FAILED;
         end else if (converter_word[2]) begin
            state_next.error_count = errors_bumped;
            result.status          = ST_OPEN;
         end else if (value == 10'd0 || {1'b0, value} > range_top) begin
            state_next.error_count = errors_bumped;
            result.status          = ST_RANGE;
         end else if (state_now.held_temp != 10'd0 && diff > cfg.jump_limit) begin
            state_next.error_count = errors_bumped;
            result.status          = ST_JUMP;
         end else begin
            state_next.error_count = '0;
            state_next.held_temp   = value;
            result.temperature     = value;
            result.status          = ST_OK;
         end
      end
      result.errors_now = state_next.error_count;
   end

endmodule

`default_nettype wire

// File: src/thermocouple_sample_qualifier_unit.sv
// thermocouple_sample_qualifier_unit: top level of the thermocouple sample qualifier
//
// Each req transaction is one tick carrying the current converter word. Every
// tick yields exactly one rsp transaction with the held temperature, a status
// code and the consecutive error count after that tick.
// A tick accepted at one edge is offered on rsp from the next cycle. Throughput
// is one tick per cycle while rsp is not stalled; the only path is the decision
// logic between the tick state registers and the rsp output register.
// req_tready is high while the output register is empty or being taken, so a
// stalled receiver holds the pending result and blocks only further ticks.
// The csr port writes a register at each edge where csr_wr_en is high; write
// it only while no transaction is in flight. Any write to probe_enable also
// clears the failed mark.
// Synchronous reset empties the output register, clears tick count, held
// temperature, error count and failed mark, and loads the register defaults
// (probe disabled, max 1023, interval 100, jump 50, error limit 4).
`default_nettype none

module thermocouple_sample_qualifier_unit
   import tsq_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // tick channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] converter_word
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] temperature, [12:10] status, [15:13] errors_now
   // configuration
   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff;

   tsq_step u_step (
      .cfg            (cfg_ff),
      .state_now      (state_ff),
      .converter_word (req_tdata),
      .state_next     (state_in),
      .result         (result_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.probe_enable    <= 1'b0;
         cfg_ff.max_temp        <= MAX_TEMP_RESET;
         cfg_ff.sample_interval <= SAMPLE_INTERVAL_RESET;
         cfg_ff.jump_limit      <= JUMP_LIMIT_RESET;
         cfg_ff.error_limit     <= ERROR_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PROBE_ENABLE:    cfg_ff.probe_enable    <= csr_wdata[0];
            REG_MAX_TEMP:        cfg_ff.max_temp        <= csr_wdata[9:0];
            REG_SAMPLE_INTERVAL: cfg_ff.sample_interval <= csr_wdata;
            REG_JUMP_LIMIT:      cfg_ff.jump_limit      <= csr_wdata[9:0];
            REG_ERROR_LIMIT:     cfg_ff.error_limit     <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // tick state, failed mark cleared by an enable write
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (csr_wr_en && csr_index == REG_PROBE_ENABLE) begin
            state_ff.probe_failed <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   // a pending result that is not taken blocks new ticks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("tick accepted while result stalled");

   // every accepted tick is offered on the result side next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // a disabled or failed probe reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.status == ST_OFF || result_ff.status == ST_FAILED)
      |-> result_ff.temperature == 10'd0)
      else $error("disabled or failed probe reports a temperature");

   // a failure clears the error count and sets the failed mark
   assert property (@(posedge clock) disable iff (reset)
      req_fire && result_in.status == ST_FAILED |=> state_ff.error_count == 3'd0)
      else $error("error count not cleared on failure");

endmodule

`default_nettype wire

// File: bench/tsq_checker.sv
// tsq_checker: tick predictor and result scoreboard for the thermocouple sample qualifier
module tsq_checker
   import tsq_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire [15:0] req_tdata,   // [15:0] converter_word
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [15:0] rsp_tdata,   // [9:0] temperature, [12:10] status, [15:13] errors_now
   input  wire        csr_wr_en,
   input  wire [2:0]  csr_index,
   input  wire [15:0] csr_wdata,
   output int         mismatches,
   output int         awaiting,
   output int         checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 40;

   cfg_type    settings;
   state_type  probe_state;
   result_type readings_due[$];
   int         fail_total = 0;
   int         checked_total = 0;

   // consecutive rejection count, saturating
   function automatic void count_reject();
      if (probe_state.error_count != ERRORS_MAX)
         probe_state.error_count++;
   endfunction

   // advance the predicted probe state by one tick and return the reading it gives
   function automatic result_type qualify_tick(input logic [15:0] word);
      result_type r;
      logic [9:0] scaled;
      logic [9:0] change;
      scaled = word[14:5];
      change = (scaled > probe_state.held_temp) ? scaled - probe_state.held_temp
                                                : probe_state.held_temp - scaled;
      if (probe_state.tick_count != TICK_MAX)
         probe_state.tick_count++;
      if (!settings.probe_enable || probe_state.probe_failed) begin
         probe_state.held_temp = '0;
         r.status = ST_OFF;
      end else if (probe_state.tick_count <= settings.sample_interval) begin
         r.status = ST_WAIT;
      end else begin
         probe_state.tick_count = '0;
         if (probe_state.error_count > settings.error_limit) begin
            // too many rejections in a row: probe declared failed, word ignored
            probe_state.probe_failed = 1'b1;
            probe_state.error_count  = '0;
            probe_state.held_temp    = '0;
            r.status = ST_FAILED;
         end else if (word[2]) begin
            count_reject();
            r.status = ST_OPEN;
         end else if (scaled == '0 ||
                      {1'b0, scaled} > {1'b0, settings.max_temp} + RANGE_MARGIN) begin
            count_reject();
            r.status = ST_RANGE;
         end else if (probe_state.held_temp != '0 && change > settings.jump_limit) begin
            count_reject();
            r.status = ST_JUMP;
         end else begin
            probe_state.error_count = '0;
            probe_state.held_temp   = scaled;
            r.status = ST_OK;
         end
      end
      // disabled and failed paths have already cleared the held value
      r.temperature = probe_state.held_temp;
      r.errors_now  = probe_state.error_count;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [9:0] want,
                                       input logic [9:0] got);
      if (got !== want) begin
         if (fail_total < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         settings = '{probe_enable: 1'b0, max_temp: MAX_TEMP_RESET,
                      sample_interval: SAMPLE_INTERVAL_RESET,
                      jump_limit: JUMP_LIMIT_RESET, error_limit: ERROR_LIMIT_RESET};
         probe_state = '0;
         readings_due.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               REG_PROBE_ENABLE: begin
                  settings.probe_enable    = csr_wdata[0];
                  probe_state.probe_failed = 1'b0;
               end
               REG_MAX_TEMP:        settings.max_temp        = csr_wdata[9:0];
               REG_SAMPLE_INTERVAL: settings.sample_interval = csr_wdata;
               REG_JUMP_LIMIT:      settings.jump_limit      = csr_wdata[9:0];
               REG_ERROR_LIMIT:     settings.error_limit     = csr_wdata[2:0];
               default: ;
            endcase
         end
         // result transaction against the oldest outstanding reading
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            checked_total++;
            if (readings_due.size() == 0) begin
               if (fail_total < MAX_REPORTS)
                  $display("%0t: unexpected result, expected none, got temp %0d status %0d errors %0d",
                           $time, seen.temperature, seen.status, seen.errors_now);
               fail_total++;
            end else begin
               want = readings_due.pop_front();
               check_field("temperature", want.temperature, seen.temperature);
               check_field("status", 10'(want.status), 10'(seen.status));
               check_field("errors_now", 10'(want.errors_now), 10'(seen.errors_now));
            end
         end
         // tick transaction
         if (req_tvalid && req_tready)
            readings_due.push_back(qualify_tick(req_tdata));
      end
      mismatches <= fail_total;
      awaiting   <= readings_due.size();
      checked    <= checked_total;
   end

endmodule

// File: bench/tb.sv
// tb: stimulus, pacing and verdict for the thermocouple sample qualifier
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsq_pkg::*;

   localparam int CYCLE_LIMIT         = 1_000_000;
   localparam int RANDOM_PHASES       = 8;
   localparam int ITEMS_PER_PHASE     = 52;
   localparam int LONG_INTERVAL_TICKS = 8;

   typedef enum int {
      PACE_FREE,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_mode;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [15:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b1;
   wire  [15:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int mismatches;
   int awaiting;
   int checked;
   int idle_pct = 0;
   int stall_pct = 0;
   int ticks_sent = 0;
   int cycles = 0;

   thermocouple_sample_qualifier_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tsq_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaiting   (awaiting),
      .checked    (checked)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings outstanding", cycles, awaiting);
         $display("thermocouple_sample_qualifier_unit test failed");
         $finish;
      end
   end

   // converter word: bit 2 open sensor, bits 14:5 scaled value, the rest noise
   function automatic logic [15:0] pack_word(input logic [9:0] value, input logic open);
      return {1'($urandom), value, 2'($urandom), open, 2'($urandom)};
   endfunction

   function automatic void set_pacing(input pace_mode mode);
      case (mode)
         PACE_FREE:           begin idle_pct = 0;  stall_pct = 0;  end
         PACE_SENDER_IDLE:    begin idle_pct = 70; stall_pct = 0;  end
         PACE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 70; end
         default:             begin idle_pct = 19; stall_pct = 19; end
      endcase
   endfunction

   // one tick transaction, with optional idle cycles ahead of it
   task automatic send_tick(input logic [15:0] word);
      while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ticks_sent++;
   endtask

   // register write; junk above the register width must be ignored
   task automatic write_reg(input logic [2:0] idx, input int value, input int width);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (16'($urandom) << width) | 16'(value);
      @(posedge clock);
   endtask

   task automatic apply_settings(input int en, input int max_t, input int interval,
                                 input int jump_lim, input int err_lim);
      write_reg(REG_MAX_TEMP, max_t, 10);
      write_reg(REG_SAMPLE_INTERVAL, interval, 16);
      write_reg(REG_JUMP_LIMIT, jump_lim, 10);
      write_reg(REG_ERROR_LIMIT, err_lim, 3);
      write_reg(REG_PROBE_ENABLE, en, 1);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // hold the sender until every reading has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      int          p;
      int          n;
      int          pick;
      int          walk;
      int          ceiling;
      int          step;
      int          max_t;
      int          jump_lim;
      int          interval;
      int          err_lim;
      logic [15:0] word;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: probe disabled out of reset
      set_pacing(PACE_FREE);
      send_tick(16'h0000);
      send_tick(pack_word(10'd300, 1'b0));
      wait_idle();

      // spare register indexes must be ignored
      for (int idx = REG_ERROR_LIMIT + 1; idx < 2 ** $bits(csr_index); idx++)
         write_reg(3'(idx), $urandom, 16);
      // examine every tick, zero error tolerance: full scale, open sensor, failure
      apply_settings(1, 1023, 0, 1023, 0);
      send_tick(16'hFFFB);
      send_tick(16'hFFFF);
      send_tick(16'h0000);
      send_tick(pack_word(10'd500, 1'b0));
      wait_idle();
      // enable write clears the failed mark
      apply_settings(1, 1023, 0, 1023, 0);
      send_tick(pack_word(10'd1, 1'b0));
      wait_idle();

      // lowest maximum: zero reading and the margin edge
      apply_settings(1, 0, 0, 1023, 7);
      send_tick(16'h0000);
      send_tick(pack_word(10'd5, 1'b0));
      send_tick(pack_word(10'd6, 1'b0));
      send_tick(pack_word(10'd5, 1'b0));
      wait_idle();

      // no jump allowed, error count saturates with the probe never failing
      apply_settings(1, 1023, 0, 0, 7);
      send_tick(pack_word(10'd5, 1'b0));
      send_tick(pack_word(10'd6, 1'b0));
      send_tick(pack_word(10'd4, 1'b0));
      repeat (6) send_tick(pack_word(10'($urandom), 1'b1));
      send_tick(pack_word(10'd5, 1'b0));
      wait_idle();

      // waiting ticks between examinations
      apply_settings(1, 1023, 2, 0, 7);
      repeat (3) send_tick(pack_word(10'd5, 1'b0));
      wait_idle();

      // disabling clears the held value
      apply_settings(0, 1023, 2, 0, 7);
      repeat (2) send_tick(pack_word(10'd5, 1'b0));
      wait_idle();

      // largest interval: nothing is examined
      apply_settings(1, 1023, 65535, 50, 4);
      repeat (LONG_INTERVAL_TICKS) send_tick(16'($urandom));
      wait_idle();

      // random phases: mostly plausible readings along a slow walk, plus faults
      for (p = 0; p < RANDOM_PHASES; p++) begin
         max_t    = (p == 3) ? 0 : (p % 2 == 0) ? 1023 : $urandom_range(0, 1023);
         jump_lim = (p == 2) ? 0 : (p == 4) ? 1023 : $urandom_range(1, 120);
         interval = (p == 6) ? $urandom_range(4, 9) : $urandom_range(0, 3);
         err_lim  = (p == 7) ? 7 : (p == 0) ? 0 : $urandom_range(0, 6);
         apply_settings((p == 5) ? 0 : 1, max_t, interval, jump_lim, err_lim);
         set_pacing(pace_mode'(p % 4));
         ceiling = (max_t + 5 > 1023) ? 1023 : max_t + 5;
         walk = $urandom_range(1, ceiling);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               step = jump_lim / 4;
               walk = walk + int'($urandom_range(0, 2 * step)) - step;
               if (walk < 1)
                  walk = 1;
               if (walk > ceiling)
                  walk = ceiling;
               word = pack_word(10'(walk), 1'b0);
            end else if (pick < 83) begin
               word = pack_word(10'($urandom), 1'b1);
            end else if (pick < 90) begin
               if (ceiling < 1023 && $urandom_range(0, 1) == 1)
                  word = pack_word(10'($urandom_range(ceiling + 1, 1023)), 1'b0);
               else
                  word = pack_word('0, 1'b0);
            end else begin
               word = 16'($urandom);
            end
            send_tick(word);
         end
         wait_idle();
         set_pacing(PACE_FREE);
      end

      repeat (4) @(posedge clock);
      $display("covered %0d ticks: directed edge cases, largest interval, %0d random settings",
               ticks_sent, RANDOM_PHASES);
      $display("%0d results checked under four pacing patterns, %0d mismatches",
               checked, mismatches);
      if (mismatches == 0 && awaiting == 0)
         $display("thermocouple_sample_qualifier_unit test passed");
      else
         $display("thermocouple_sample_qualifier_unit test failed");
      $finish;
   end

endmodule
